>>> rtl/core/oat_pkg.sv
// Package for the ordered array table: field widths, request and status codes,
// operation and state enums, and the queue entry struct.
// No dependencies; every file of the block imports it.
package oat_pkg;

	// Default configuration
	localparam int CAPACITY_DEF  = 16;
	localparam int WORD_BITS_DEF = 32;

	// Port field widths
	localparam int REQ_TYPE_BITS = 3;
	localparam int POS_BITS      = 5;
	localparam int VALUE_BITS    = 32;
	localparam int STATUS_BITS   = 2;
	localparam int MIDX_BITS     = 4;
	localparam int COUNT_BITS    = 5;

	// Request queue depth between front and back
	localparam int QDEPTH     = 2;
	localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	// Request codes on req_type
	localparam logic [REQ_TYPE_BITS-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_ERASE  = 3'd3;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_FIND   = 3'd4;

	// Status codes on status
	localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd3;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_INSERT,
		OP_ERASE,
		OP_FIND,
		OP_NOP
	} op_t;

	// Back-end sequencer states
	typedef enum logic {
		ST_RUN,
		ST_FIND
	} state_t;

	// Queue entry control part (the word travels beside it)
	typedef struct packed {
		op_t                 op;
		logic [POS_BITS-1:0] position;
	} req_t;

endpackage

>>> rtl/core/oat_front.sv
// Front end of the ordered array table: accepts request beats, classifies
// the request code and holds decoded requests in a short queue.
// Depends on oat_pkg.
module oat_front #(
	parameter int WORD_BITS = oat_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [oat_pkg::REQ_TYPE_BITS-1:0]   req_type,
	input  logic [oat_pkg::POS_BITS-1:0]        position,
	input  logic signed [oat_pkg::VALUE_BITS-1:0] value,
	output logic                                q_valid,
	output oat_pkg::req_t                       q_head,
	output logic [WORD_BITS-1:0]                q_word,
	input  logic                                q_pop
);
	import oat_pkg::*;

	req_t                 slot_q [QDEPTH];
	logic [WORD_BITS-1:0] word_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	req_t                 dec;
	logic                 push;

	// Classify the request code
	always_comb begin
		dec.position = position;
		case (req_type)
			REQ_PUSH:   dec.op = OP_PUSH;
			REQ_POP:    dec.op = OP_POP;
			REQ_INSERT: dec.op = OP_INSERT;
			REQ_ERASE:  dec.op = OP_ERASE;
			REQ_FIND:   dec.op = OP_FIND;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign req_stall = (cnt_q == QCNT_BITS'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_head    = slot_q[rd_q];
	assign q_word    = word_q[rd_q];

	// Store accepted beats; stored word keeps only the low WORD_BITS bits
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= dec;
			word_q[wr_q] <= WORD_BITS'($unsigned(value));
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop)
				rd_q <= (rd_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (q_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/oat_back.sv
// Back end of the ordered array table: the entry cells and fill count,
// request execution, find match scanning and the result register.
// Depends on oat_pkg.
module oat_back #(
	parameter int CAPACITY  = oat_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = oat_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  oat_pkg::req_t                     q_head,
	input  logic [WORD_BITS-1:0]              q_word,
	output logic                              q_pop,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [oat_pkg::STATUS_BITS-1:0]   status,
	output logic                              match_found,
	output logic [oat_pkg::MIDX_BITS-1:0]     match_index,
	output logic [oat_pkg::COUNT_BITS-1:0]    count,
	output logic                              last
);
	import oat_pkg::*;

	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

	logic [WORD_BITS-1:0]   entries_q [CAPACITY];
	logic [WORD_BITS-1:0]   entries_nx [CAPACITY];
	logic [CNT_BITS-1:0]    fill_q;
	logic [CNT_BITS-1:0]    fill_nx;
	logic [CAPACITY-1:0]    mask_q;
	logic [CAPACITY-1:0]    match_vec;
	logic [CAPACITY-1:0]    mask_rest;
	logic [IDX_BITS-1:0]    low_idx;
	state_t                 state_q;
	state_t                 state_nx;
	logic                   load;
	logic                   emit_op;
	logic                   emit_find;
	logic                   find_start;
	logic                   find_last;
	logic [STATUS_BITS-1:0] op_status;
	logic [CMP_BITS-1:0]    pos_w;
	logic [CMP_BITS-1:0]    fill_w;

	logic                   res_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic                   match_found_q;
	logic [MIDX_BITS-1:0]   match_index_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   last_q;

	assign load   = !res_valid_q || !res_stall;
	assign pos_w  = CMP_BITS'(q_head.position);
	assign fill_w = CMP_BITS'(fill_q);

	// Compute status, new cells and new fill count of a non-find request
	always_comb begin
		op_status = STATUS_DONE;
		fill_nx   = fill_q;
		for (int i = 0; i < CAPACITY; i++)
			entries_nx[i] = entries_q[i];
		case (q_head.op)
			OP_PUSH: begin
				if (fill_w >= CMP_BITS'(CAPACITY)) begin
					op_status = STATUS_FULL;
				end else begin
					for (int i = 0; i < CAPACITY; i++)
						if (CMP_BITS'(i) == fill_w)
							entries_nx[i] = q_word;
					fill_nx = fill_q + 1'b1;
				end
			end
			OP_POP: begin
				if (fill_q == '0)
					op_status = STATUS_EMPTY;
				else
					fill_nx = fill_q - 1'b1;
			end
			OP_INSERT: begin
				if (pos_w > fill_w) begin
					op_status = STATUS_RANGE;
				end else if (fill_w >= CMP_BITS'(CAPACITY)) begin
					op_status = STATUS_FULL;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (CMP_BITS'(i) == pos_w)
							entries_nx[i] = q_word;
						else if (CMP_BITS'(i) > pos_w && i > 0)
							entries_nx[i] = entries_q[(i > 0) ? i - 1 : 0];
					end
					fill_nx = fill_q + 1'b1;
				end
			end
			OP_ERASE: begin
				if (pos_w >= fill_w) begin
					op_status = STATUS_RANGE;
				end else begin
					for (int i = 0; i + 1 < CAPACITY; i++)
						if (CMP_BITS'(i) >= pos_w)
							entries_nx[i] = entries_q[i + 1];
					fill_nx = fill_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Compare every held entry against the searched word
	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			match_vec[i] = (CMP_BITS'(i) < fill_w) && (entries_q[i] == q_word);
	end

	// Pick the lowest pending match and drop it from the mask
	always_comb begin
		low_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (mask_q[i])
				low_idx = IDX_BITS'(i);
	end
	assign mask_rest = mask_q & (mask_q - 1'b1);
	assign find_last = (mask_rest == '0);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_RUN:
				if (q_valid && load && q_head.op == OP_FIND)
					state_nx = ST_FIND;
			ST_FIND:
				if (load && find_last)
					state_nx = ST_RUN;
			default:
				state_nx = ST_RUN;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop      = 1'b0;
		emit_op    = 1'b0;
		emit_find  = 1'b0;
		find_start = 1'b0;
		case (state_q)
			ST_RUN:
				if (q_valid && load) begin
					q_pop = 1'b1;
					if (q_head.op == OP_FIND)
						find_start = 1'b1;
					else
						emit_op = 1'b1;
				end
			ST_FIND:
				emit_find = load;
			default: ;
		endcase
	end

	// Update cells and pending match mask
	always_ff @(posedge clk) begin
		if (emit_op && op_status == STATUS_DONE) begin
			for (int i = 0; i < CAPACITY; i++)
				entries_q[i] <= entries_nx[i];
		end
		if (find_start)
			mask_q <= match_vec;
		else if (emit_find)
			mask_q <= mask_rest;
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit_op)
				fill_q <= fill_nx;
			if (emit_op || emit_find)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (emit_op) begin
			status_q      <= op_status;
			match_found_q <= 1'b0;
			match_index_q <= '0;
			count_q       <= COUNT_BITS'(fill_nx);
			last_q        <= 1'b1;
		end else if (emit_find) begin
			status_q      <= STATUS_DONE;
			match_found_q <= (mask_q != '0);
			match_index_q <= (mask_q != '0) ? MIDX_BITS'(low_idx) : '0;
			count_q       <= COUNT_BITS'(fill_q);
			last_q        <= find_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign match_found = match_found_q;
	assign match_index = match_index_q;
	assign count       = count_q;
	assign last        = last_q;

endmodule

>>> rtl/core/ordered_array_table.sv
// Ordered array table top level: a fixed-capacity ordered list of words
// with push, pop, insert, erase and find requests.
// Depends on oat_pkg, oat_front and oat_back.
//
// Usage:
//   Request channel: req_valid/req_stall with req_type, position, value.
//   Result channel: res_valid/res_stall with status, match_found,
//   match_index, count, last. A beat moves when valid is high and stall low.
//   Every request gives one result beat, except find, which gives one beat
//   per matching index in ascending order (or one not-found beat); the
//   final beat of each request has last set.
//   Order: a request beat is registered in the request queue, then its result
//   in the result register. Push, pop, insert, erase and unknown codes execute
//   straight from the queue head; a find first loads its match mask, then the
//   single result register delivers one match per cycle while not stalled.
//   A two-entry request queue keeps accepting beats while the back end
//   works or the receiver stalls; req_stall rises only when it is full.
//   When res_stall is high while a result is valid, the result register holds and the back end waits.
//   Reset empties the table and the queue and drops any pending result;
//   entry contents are not cleared.
module ordered_array_table #(
	parameter int CAPACITY  = oat_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = oat_pkg::WORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [oat_pkg::REQ_TYPE_BITS-1:0]     req_type,
	input  logic [oat_pkg::POS_BITS-1:0]          position,
	input  logic signed [oat_pkg::VALUE_BITS-1:0] value,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic [oat_pkg::STATUS_BITS-1:0]       status,
	output logic                                  match_found,
	output logic [oat_pkg::MIDX_BITS-1:0]         match_index,
	output logic [oat_pkg::COUNT_BITS-1:0]        count,
	output logic                                  last
);
	import oat_pkg::*;

	logic                 q_valid;
	req_t                 q_head;
	logic [WORD_BITS-1:0] q_word;
	logic                 q_pop;

	oat_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.position  (position),
		.value     (value),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_word    (q_word),
		.q_pop     (q_pop)
	);

	oat_back #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_word      (q_word),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.match_found (match_found),
		.match_index (match_index),
		.count       (count),
		.last        (last)
	);

endmodule
